// ----- rtl/das_pkg.sv -----
// ----------------------------------------------------------------------------
// das_pkg
// Shared widths, codes and helpers for the door access sequencer.
// ----------------------------------------------------------------------------
package das_pkg;

  localparam int UID_BYTES = 7;
  localparam int UID_W     = 8 * UID_BYTES;
  localparam int CNT_W     = 3;
  localparam int MS_W      = 20;
  localparam int ADDR_W    = 8;
  localparam int MODE_W    = 3;
  localparam int CMD_W     = 2;
  localparam int MSG_W     = 2;
  localparam int RESP_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 20;

  // stream payload widths, rounded up to whole bytes
  localparam int IN_BITS   = 1 + UID_W + CNT_W + RESP_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = UID_W + CNT_W + MODE_W + 3 + ADDR_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [MODE_W-1:0] MODE_IDLE       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_VALIDATING = 3'd1;
  localparam logic [MODE_W-1:0] MODE_UNLOCKED   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_OPEN       = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DENIED     = 3'd4;

  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CARD     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESPONSE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_IDENTITY = 2'd3;

  localparam logic [MSG_W-1:0] MSG_NONE      = 2'd0;
  localparam logic [MSG_W-1:0] MSG_AUTHORIZE = 2'd1;
  localparam logic [MSG_W-1:0] MSG_CONFIRMED = 2'd2;
  localparam logic [MSG_W-1:0] MSG_IDENTITY  = 2'd3;

  localparam logic [RESP_W-1:0] RESP_GRANTED = 2'd0;
  localparam logic [RESP_W-1:0] RESP_DENIED  = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_VALIDATING_TIMEOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNLOCKED_TIMEOUT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_ALARM         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DENIED_HOLD        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDRESS       = 3'd4;

  localparam logic [MS_W-1:0]   RST_VALIDATING_TIMEOUT = 20'd5000;
  localparam logic [MS_W-1:0]   RST_UNLOCKED_TIMEOUT   = 20'd5000;
  localparam logic [MS_W-1:0]   RST_OPEN_ALARM         = 20'd10000;
  localparam logic [MS_W-1:0]   RST_DENIED_HOLD        = 20'd3000;
  localparam logic [ADDR_W-1:0] RST_NODE_ADDRESS       = 8'd17;

  localparam logic [MS_W-1:0] MS_MAX = '1;
  localparam logic [3:0] DIR_INBOUND  = 4'h1;
  localparam logic [3:0] DIR_OUTBOUND = 4'h2;

  // keep only the low count bytes of a UID
  function automatic logic [UID_W-1:0] uid_keep(input logic [UID_W-1:0] uid,
                                                input logic [CNT_W-1:0] count);
    logic [UID_W-1:0] kept;
    kept = '0;
    for (int i = 0; i < UID_BYTES; i++) begin
      if (i < int'(count)) begin
        kept[8*i +: 8] = uid[8*i +: 8];
      end
    end
    return kept;
  endfunction

  // direction 1 becomes 2, anything else becomes 1
  function automatic logic [ADDR_W-1:0] flip_direction(input logic [ADDR_W-1:0] addr);
    return {addr[7:4], (addr[3:0] == DIR_INBOUND) ? DIR_OUTBOUND : DIR_INBOUND};
  endfunction

endpackage

// ----- rtl/door_access_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// door_access_sequencer_core
// Door access sequencer: card, authorization and 1 ms tick handling.
// ----------------------------------------------------------------------------
// One result item comes out for every input item. The block takes one item
// per clock as long as the result side keeps taking items: an item is
// held in the input register, is resolved against the mode, timer and
// LED state in a single pass, and lands in the result register. Timeouts
// are counted in tick items, not clock cycles. Configuration writes must be
// made while no item is in flight.
module door_access_sequencer_core (
  input  logic                                  clk,
  input  logic                                  rst,
  // s_tdata, lowest bit up: door_pressed, card_uid, card_uid_count,
  // response_code, zero fill
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [das_pkg::IN_DATA_W-1:0]         s_tdata,
  input  logic [das_pkg::CMD_W-1:0]             s_tuser,   // command
  // m_tdata, lowest bit up: message_uid, message_uid_count, door_mode,
  // granted_led, denied_led, buzzer_level, node_address, zero fill
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [das_pkg::OUT_DATA_W-1:0]        m_tdata,
  output logic [das_pkg::MSG_W-1:0]             m_tuser,   // message_kind
  input  logic                                  cfg_we,
  input  logic [das_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [das_pkg::CFG_W-1:0]             cfg_data
);
  import das_pkg::*;

  // configuration
  logic [MS_W-1:0]   validating_timeout;
  logic [MS_W-1:0]   unlocked_timeout;
  logic [MS_W-1:0]   open_alarm;
  logic [MS_W-1:0]   denied_hold;

  // input register
  logic                 in_valid;
  logic [CMD_W-1:0]     in_cmd;
  logic                 in_pressed;
  logic [UID_W-1:0]     in_uid;
  logic [CNT_W-1:0]     in_count;
  logic [RESP_W-1:0]    in_resp;

  // sequencer state
  logic [MODE_W-1:0]    mode, mode_next;
  logic [MS_W-1:0]      elapsed, elapsed_next;
  logic [UID_W-1:0]     held_uid, held_uid_next;
  logic [CNT_W-1:0]     held_count, held_count_next;
  logic                 alarm_on, alarm_on_next;
  logic                 granted_on, granted_on_next;
  logic                 denied_on, denied_on_next;
  logic [ADDR_W-1:0]    address, address_next;
  logic [MSG_W-1:0]     msg_next;

  logic [MS_W-1:0]      elapsed_inc;
  logic [CNT_W-1:0]     count_sat;
  logic                 advance;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_cmd     <= s_tuser;
      in_pressed <= s_tdata[0];
      in_uid     <= s_tdata[UID_W:1];
      in_count   <= s_tdata[UID_W+CNT_W:UID_W+1];
      in_resp    <= s_tdata[UID_W+CNT_W+RESP_W:UID_W+CNT_W+1];
    end
  end

  assign elapsed_inc = (elapsed == MS_MAX) ? elapsed : elapsed + 1'b1;
  assign count_sat   = (int'(in_count) > UID_BYTES) ? CNT_W'(UID_BYTES) : in_count;

  always_comb begin
    mode_next       = mode;
    elapsed_next    = elapsed;
    held_uid_next   = held_uid;
    held_count_next = held_count;
    alarm_on_next   = alarm_on;
    granted_on_next = granted_on;
    denied_on_next  = denied_on;
    address_next    = address;
    msg_next        = MSG_NONE;
    case (in_cmd)
      CMD_TICK: begin
        elapsed_next = elapsed_inc;
        case (mode)
          MODE_IDLE: begin
            // forced door
            if (in_pressed) begin
              mode_next      = MODE_DENIED;
              elapsed_next   = '0;
              denied_on_next = 1'b1;
            end
          end
          MODE_VALIDATING: begin
            if (elapsed_inc >= validating_timeout) begin
              mode_next = MODE_DENIED;
            end
          end
          MODE_UNLOCKED: begin
            if (elapsed_inc >= unlocked_timeout) begin
              granted_on_next = 1'b0;
              mode_next       = MODE_IDLE;
            end else if (in_pressed) begin
              msg_next     = MSG_CONFIRMED;
              mode_next    = MODE_OPEN;
              elapsed_next = '0;
            end
          end
          MODE_OPEN: begin
            if (!in_pressed) begin
              alarm_on_next   = 1'b0;
              granted_on_next = 1'b0;
              address_next    = flip_direction(address);
              mode_next       = MODE_IDLE;
            end else if (!alarm_on && elapsed_inc >= open_alarm) begin
              alarm_on_next = 1'b1;
            end
          end
          MODE_DENIED: begin
            if (elapsed_inc >= denied_hold) begin
              denied_on_next = 1'b0;
              mode_next      = MODE_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
      CMD_CARD: begin
        if (mode == MODE_IDLE) begin
          held_count_next = count_sat;
          held_uid_next   = uid_keep(in_uid, count_sat);
          mode_next       = MODE_VALIDATING;
          elapsed_next    = '0;
          msg_next        = MSG_AUTHORIZE;
        end
      end
      CMD_RESPONSE: begin
        if (mode == MODE_VALIDATING) begin
          if (in_resp == RESP_GRANTED) begin
            granted_on_next = 1'b1;
            mode_next       = MODE_UNLOCKED;
          end else if (in_resp == RESP_DENIED) begin
            denied_on_next = 1'b1;
            mode_next      = MODE_DENIED;
          end
        end
      end
      default: begin
        msg_next = MSG_IDENTITY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      validating_timeout <= RST_VALIDATING_TIMEOUT;
      unlocked_timeout   <= RST_UNLOCKED_TIMEOUT;
      open_alarm         <= RST_OPEN_ALARM;
      denied_hold        <= RST_DENIED_HOLD;
      mode       <= MODE_IDLE;
      elapsed    <= '0;
      held_uid   <= '0;
      held_count <= '0;
      alarm_on   <= 1'b0;
      granted_on <= 1'b0;
      denied_on  <= 1'b0;
      address    <= RST_NODE_ADDRESS;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_VALIDATING_TIMEOUT: validating_timeout <= cfg_data[MS_W-1:0];
          CFG_UNLOCKED_TIMEOUT:   unlocked_timeout   <= cfg_data[MS_W-1:0];
          CFG_OPEN_ALARM:         open_alarm         <= cfg_data[MS_W-1:0];
          CFG_DENIED_HOLD:        denied_hold        <= cfg_data[MS_W-1:0];
          CFG_NODE_ADDRESS:       address            <= cfg_data[ADDR_W-1:0];
          default: begin
          end
        endcase
      end
      if (advance) begin
        m_tvalid <= in_valid;
      end
      if (in_valid && advance) begin
        mode       <= mode_next;
        elapsed    <= elapsed_next;
        held_uid   <= held_uid_next;
        held_count <= held_count_next;
        alarm_on   <= alarm_on_next;
        granted_on <= granted_on_next;
        denied_on  <= denied_on_next;
        address    <= address_next;
      end
    end
    // result payload
    if (in_valid && advance) begin
      m_tuser <= msg_next;
      if (msg_next == MSG_AUTHORIZE || msg_next == MSG_CONFIRMED) begin
        m_tdata[UID_W-1:0]           <= held_uid_next;
        m_tdata[UID_W+CNT_W-1:UID_W] <= held_count_next;
      end else begin
        m_tdata[UID_W+CNT_W-1:0] <= '0;
      end
      m_tdata[UID_W+CNT_W+MODE_W-1:UID_W+CNT_W] <= mode_next;
      m_tdata[UID_W+CNT_W+MODE_W]     <= granted_on_next;
      m_tdata[UID_W+CNT_W+MODE_W+1]   <= denied_on_next;
      m_tdata[UID_W+CNT_W+MODE_W+2]   <= alarm_on_next;
      m_tdata[OUT_BITS-1:OUT_BITS-ADDR_W] <= address_next;
      m_tdata[OUT_DATA_W-1:OUT_BITS]  <= '0;
    end
  end

`ifndef SYNTHESIS
  a_alarm_only_open: assert property (@(posedge clk) disable iff (rst)
    alarm_on |-> mode == MODE_OPEN)
    else $error("buzzer on outside open mode");

  a_granted_mode: assert property (@(posedge clk) disable iff (rst)
    granted_on |-> (mode == MODE_UNLOCKED || mode == MODE_OPEN))
    else $error("granted LED on outside unlocked or open mode");

  a_denied_mode: assert property (@(posedge clk) disable iff (rst)
    denied_on |-> mode == MODE_DENIED)
    else $error("denied LED on outside denied mode");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |-> !s_tready)
    else $error("input register would be overwritten while stalled");
`endif

endmodule

// ----- test/door_access_sequencer_core_test.sv -----
// ----------------------------------------------------------------------------
// door_access_sequencer_core_test
// Self-checking bench for the door access sequencer. A clocked driver feeds
// queued items through the input stream, and an in-bench model of the mode,
// timer, LED and address state predicts the result of each accepted item.
// A clocked monitor compares every result field by field. Short directed
// visits come first, then random visits under several timeout and address
// settings, with random idling on both streams.
// ----------------------------------------------------------------------------
module door_access_sequencer_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import das_pkg::*;

  localparam int ITEM_GOAL   = 1450;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_PRINT   = 40;

  // response codes the block ignores
  localparam logic [RESP_W-1:0] RESP_OTHER = 2'd2;
  localparam logic [RESP_W-1:0] RESP_SPARE = 2'd3;

  // sensor level pattern for a run of ticks
  localparam int PRESS_LOW  = 0;
  localparam int PRESS_HIGH = 1;
  localparam int PRESS_RAND = 2;

  // timeout setting styles
  localparam int LIM_SMALL = 0;
  localparam int LIM_ZERO  = 1;
  localparam int LIM_FULL  = 2;
  localparam int LIM_MIXED = 3;

  // result field offsets in m_tdata
  localparam int O_CNT   = UID_W;
  localparam int O_MODE  = O_CNT + CNT_W;
  localparam int O_GRANT = O_MODE + MODE_W;
  localparam int O_DENY  = O_GRANT + 1;
  localparam int O_BUZZ  = O_DENY + 1;
  localparam int O_ADDR  = O_BUZZ + 1;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic              pressed;
    logic [UID_W-1:0]  uid;
    logic [CNT_W-1:0]  cnt;
    logic [RESP_W-1:0] code;
  } door_item_t;

  typedef struct packed {
    logic [MSG_W-1:0]  kind;
    logic [UID_W-1:0]  uid;
    logic [CNT_W-1:0]  cnt;
    logic [MODE_W-1:0] door;
    logic              grant;
    logic              deny;
    logic              buzz;
    logic [ADDR_W-1:0] addr;
  } door_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [CMD_W-1:0]      s_tuser = CMD_TICK;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [MSG_W-1:0]      m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_VALIDATING_TIMEOUT;
  logic [CFG_W-1:0]      cfg_data = '0;

  door_access_sequencer_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // door model state and settings
  logic [MODE_W-1:0] door_state = MODE_IDLE;
  logic [MS_W-1:0]   ms_count   = '0;
  logic [UID_W-1:0]  held_uid   = '0;
  logic [CNT_W-1:0]  held_cnt   = '0;
  logic              buzz_on    = 1'b0;
  logic              green_on   = 1'b0;
  logic              red_on     = 1'b0;
  logic [ADDR_W-1:0] node_addr  = RST_NODE_ADDRESS;
  logic [MS_W-1:0]   t_validate = RST_VALIDATING_TIMEOUT;
  logic [MS_W-1:0]   t_unlock   = RST_UNLOCKED_TIMEOUT;
  logic [MS_W-1:0]   t_alarm    = RST_OPEN_ALARM;
  logic [MS_W-1:0]   t_deny     = RST_DENIED_HOLD;

  door_item_t   items_todo[$];
  door_result_t results_due[$];
  door_item_t   cur;
  bit           in_taken = 1'b0;
  int           src_gap = 0;
  int           sink_gap = 0;
  int           src_idle_pct = 0;
  int           sink_idle_pct = 0;
  int           queued = 0;
  int           checked = 0;
  int           errors = 0;
  int           settings = 0;
  int           n_confirm = 0;
  int           n_alarm = 0;
  int           n_refused = 0;
  int           cycles = 0;

  task automatic report(input string what);
    errors++;
    if (errors <= MAX_PRINT) $display("MISMATCH: %s", what);
  endtask

  // advance the door model by one item and return the result it produces
  function automatic door_result_t step_door(input door_item_t it);
    door_result_t r;
    logic [CNT_W-1:0] n;
    r = '0;
    r.kind = MSG_NONE;
    case (it.cmd)
      CMD_TICK: begin
        if (ms_count != MS_MAX) ms_count = ms_count + 1'b1;
        case (door_state)
          MODE_IDLE: begin
            if (it.pressed) begin
              door_state = MODE_DENIED;
              ms_count = '0;
              red_on = 1'b1;
              n_refused++;
            end
          end
          MODE_VALIDATING: begin
            // timeout refuses without lighting the denied LED
            if (ms_count >= t_validate) begin
              door_state = MODE_DENIED;
              n_refused++;
            end
          end
          MODE_UNLOCKED: begin
            if (ms_count >= t_unlock) begin
              green_on = 1'b0;
              door_state = MODE_IDLE;
            end else if (it.pressed) begin
              r.kind = MSG_CONFIRMED;
              door_state = MODE_OPEN;
              ms_count = '0;
              n_confirm++;
            end
          end
          MODE_OPEN: begin
            if (!it.pressed) begin
              buzz_on = 1'b0;
              green_on = 1'b0;
              node_addr[3:0] = (node_addr[3:0] == DIR_INBOUND) ? DIR_OUTBOUND : DIR_INBOUND;
              door_state = MODE_IDLE;
            end else if (!buzz_on && ms_count >= t_alarm) begin
              buzz_on = 1'b1;
              n_alarm++;
            end
          end
          MODE_DENIED: begin
            if (ms_count >= t_deny) begin
              red_on = 1'b0;
              door_state = MODE_IDLE;
            end
          end
          default: ;
        endcase
      end
      CMD_CARD: begin
        if (door_state == MODE_IDLE) begin
          n = it.cnt;
          if (int'(n) > UID_BYTES) n = CNT_W'(UID_BYTES);
          held_cnt = n;
          held_uid = (n == 0) ? '0 :
                     it.uid & ({UID_W{1'b1}} >> (8 * (UID_BYTES - int'(n))));
          door_state = MODE_VALIDATING;
          ms_count = '0;
          r.kind = MSG_AUTHORIZE;
        end
      end
      CMD_RESPONSE: begin
        // timer keeps running from the card read
        if (door_state == MODE_VALIDATING) begin
          if (it.code == RESP_GRANTED) begin
            green_on = 1'b1;
            door_state = MODE_UNLOCKED;
          end else if (it.code == RESP_DENIED) begin
            red_on = 1'b1;
            door_state = MODE_DENIED;
            n_refused++;
          end
        end
      end
      default: begin
        r.kind = MSG_IDENTITY;
      end
    endcase
    if (r.kind == MSG_AUTHORIZE || r.kind == MSG_CONFIRMED) begin
      r.uid = held_uid;
      r.cnt = held_cnt;
    end
    r.door  = door_state;
    r.grant = green_on;
    r.deny  = red_on;
    r.buzz  = buzz_on;
    r.addr  = node_addr;
    return r;
  endfunction

  // input side: hold each item until taken, then maybe pause
  always @(negedge clk) begin : feed
    logic [IN_DATA_W-1:0] word;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (src_gap != 0) begin
        src_gap = src_gap - 1;
        s_tvalid <= 1'b0;
      end else if (items_todo.size() != 0) begin
        cur = items_todo.pop_front();
        word = '0;
        word[IN_BITS-1:0] = {cur.code, cur.cnt, cur.uid, cur.pressed};
        s_tdata <= word;
        s_tuser <= cur.cmd;
        s_tvalid <= 1'b1;
        if ($urandom_range(0, 99) < src_idle_pct) src_gap = $urandom_range(1, 16);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result side: stall in bursts
  always @(negedge clk) begin
    if (sink_gap != 0) begin
      sink_gap = sink_gap - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 99) < sink_idle_pct) sink_gap = $urandom_range(1, 16);
    end
  end

  always @(posedge clk) begin : watch
    door_result_t got;
    door_result_t want;
    in_taken = !rst && s_tvalid && s_tready;
    if (in_taken) results_due.push_back(step_door(cur));
    if (!rst && m_tvalid && m_tready) begin
      got.kind  = m_tuser;
      got.uid   = m_tdata[0 +: UID_W];
      got.cnt   = m_tdata[O_CNT +: CNT_W];
      got.door  = m_tdata[O_MODE +: MODE_W];
      got.grant = m_tdata[O_GRANT];
      got.deny  = m_tdata[O_DENY];
      got.buzz  = m_tdata[O_BUZZ];
      got.addr  = m_tdata[O_ADDR +: ADDR_W];
      if (results_due.size() == 0) begin
        report($sformatf("result %0d arrived with nothing outstanding", checked));
      end else begin
        want = results_due.pop_front();
        if (got.kind !== want.kind)
          report($sformatf("result %0d message_kind %0d, want %0d", checked, got.kind,
                           want.kind));
        if (got.uid !== want.uid)
          report($sformatf("result %0d message_uid %0h, want %0h", checked, got.uid,
                           want.uid));
        if (got.cnt !== want.cnt)
          report($sformatf("result %0d message_uid_count %0d, want %0d", checked, got.cnt,
                           want.cnt));
        if (got.door !== want.door)
          report($sformatf("result %0d door_mode %0d, want %0d", checked, got.door,
                           want.door));
        if (got.grant !== want.grant)
          report($sformatf("result %0d granted_led %0b, want %0b", checked, got.grant,
                           want.grant));
        if (got.deny !== want.deny)
          report($sformatf("result %0d denied_led %0b, want %0b", checked, got.deny,
                           want.deny));
        if (got.buzz !== want.buzz)
          report($sformatf("result %0d buzzer_level %0b, want %0b", checked, got.buzz,
                           want.buzz));
        if (got.addr !== want.addr)
          report($sformatf("result %0d node_address %0h, want %0h", checked, got.addr,
                           want.addr));
      end
      checked++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("door_access_sequencer_core_test: errors");
      $finish;
    end
  end

  function automatic door_item_t any_item(input logic [CMD_W-1:0] cmd);
    door_item_t it;
    it.cmd = cmd;
    it.pressed = 1'($urandom_range(0, 1));
    it.uid = UID_W'({$urandom, $urandom});
    it.cnt = CNT_W'($urandom_range(0, 7));
    it.code = RESP_W'($urandom_range(0, 3));
    return it;
  endfunction

  function automatic logic [UID_W-1:0] random_uid();
    if ($urandom_range(0, 7) == 0) return '1;
    return UID_W'({$urandom, $urandom});
  endfunction

  // tick runs stay short even under long timeouts
  function automatic int span(input logic [MS_W-1:0] limit);
    return (limit > 30) ? 30 : int'(limit);
  endfunction

  function automatic logic [MS_W-1:0] pick_limit(input int style);
    case (style)
      LIM_ZERO: return '0;
      LIM_FULL: return MS_MAX;
      LIM_MIXED: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return MS_MAX;
          2: return MS_W'($urandom) & MS_MAX;
          default: return MS_W'($urandom_range(0, 24));
        endcase
      end
      default: return MS_W'($urandom_range(0, 24));
    endcase
  endfunction

  task automatic push(input door_item_t it);
    items_todo.push_back(it);
    queued++;
  endtask

  task automatic queue_identity();
    push(any_item(CMD_IDENTITY));
  endtask

  task automatic queue_card(input logic [UID_W-1:0] uid, input logic [CNT_W-1:0] cnt);
    door_item_t it;
    it = any_item(CMD_CARD);
    it.uid = uid;
    it.cnt = cnt;
    push(it);
  endtask

  task automatic queue_response(input logic [RESP_W-1:0] code);
    door_item_t it;
    it = any_item(CMD_RESPONSE);
    it.code = code;
    push(it);
  endtask

  task automatic queue_ticks(input int n, input int how);
    door_item_t it;
    for (int i = 0; i < n; i++) begin
      it = any_item(CMD_TICK);
      if (how != PRESS_RAND) it.pressed = (how == PRESS_HIGH);
      push(it);
      if ($urandom_range(0, 15) == 0) queue_identity();
    end
  endtask

  // one visitor at the door, mostly well formed, sometimes garbage
  task automatic queue_visit();
    door_item_t it;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        queue_card(random_uid(), CNT_W'($urandom_range(0, 7)));
        queue_ticks($urandom_range(0, span(t_validate)), PRESS_RAND);
        if ($urandom_range(0, 3) == 0) queue_response($urandom_range(0, 1) ? RESP_OTHER : RESP_SPARE);
        queue_response(RESP_GRANTED);
        queue_ticks($urandom_range(0, span(t_unlock) + 1), PRESS_LOW);
        queue_ticks($urandom_range(1, span(t_alarm) + 3), PRESS_HIGH);
        queue_ticks($urandom_range(1, 2), PRESS_LOW);
      end
      3: begin
        queue_card(random_uid(), CNT_W'($urandom_range(0, 7)));
        queue_ticks($urandom_range(0, span(t_validate)), PRESS_RAND);
        queue_response(RESP_DENIED);
        queue_ticks(span(t_deny) + 2, PRESS_LOW);
      end
      4: begin
        queue_card(random_uid(), CNT_W'($urandom_range(0, 7)));
        queue_ticks(span(t_validate) + span(t_deny) + 3, PRESS_LOW);
        queue_response(RESP_W'($urandom_range(0, 3)));
      end
      5: begin
        queue_ticks(1, PRESS_HIGH);
        queue_ticks($urandom_range(0, span(t_deny) + 2), PRESS_RAND);
        queue_ticks(span(t_deny) + 2, PRESS_LOW);
      end
      6: begin
        for (int i = $urandom_range(4, 12); i > 0; i--) push(any_item(CMD_W'($urandom_range(0, 3))));
      end
      7: begin
        for (int i = $urandom_range(3, 8); i > 0; i--) begin
          it = any_item(CMD_W'($urandom_range(0, 2)));
          push(it);
        end
        queue_ticks($urandom_range(0, 4), PRESS_LOW);
      end
      8: begin
        queue_card(random_uid(), CNT_W'($urandom_range(0, 7)));
        queue_response(RESP_GRANTED);
        queue_ticks(span(t_unlock) + 2, PRESS_LOW);
      end
      default: begin
        queue_card(random_uid(), CNT_W'($urandom_range(0, 7)));
        queue_response(RESP_GRANTED);
        queue_ticks(1, PRESS_HIGH);
        queue_ticks(span(t_alarm) + $urandom_range(1, 6), PRESS_HIGH);
        queue_ticks(1, PRESS_LOW);
      end
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_VALIDATING_TIMEOUT: t_validate = data;
      CFG_UNLOCKED_TIMEOUT:   t_unlock = data;
      CFG_OPEN_ALARM:         t_alarm = data;
      CFG_DENIED_HOLD:        t_deny = data;
      CFG_NODE_ADDRESS:       node_addr = data[ADDR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // drain everything in flight, then let the pipeline idle before returning
  task automatic wait_idle();
    while (items_todo.size() != 0 || s_tvalid || results_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin : stimulus
    int phase;
    int stop;
    int style;
    bit last;
    logic [ADDR_W-1:0] addr;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: full grant, ignored commands, denial
    queue_identity();
    queue_response(RESP_GRANTED);
    queue_card('1, 3'd7);
    queue_card(random_uid(), 3'd4);
    queue_response(RESP_SPARE);
    queue_response(RESP_OTHER);
    queue_response(RESP_GRANTED);
    queue_ticks(2, PRESS_HIGH);
    queue_ticks(1, PRESS_LOW);
    queue_card('1, 3'd0);
    queue_response(RESP_DENIED);
    wait_idle();

    write_reg(CFG_VALIDATING_TIMEOUT, '0);
    write_reg(CFG_UNLOCKED_TIMEOUT, 20'd2);
    write_reg(CFG_OPEN_ALARM, 20'd1);
    write_reg(CFG_DENIED_HOLD, 20'd1);
    write_reg(CFG_NODE_ADDRESS, {12'hABC, 8'hFF});
    settings = 1;
    // denied hold, forced door, validating timeout, alarm, relock before press
    queue_ticks(1, PRESS_LOW);
    queue_ticks(1, PRESS_HIGH);
    queue_ticks(1, PRESS_LOW);
    queue_card(random_uid(), 3'd3);
    queue_ticks(2, PRESS_LOW);
    queue_card(random_uid(), 3'd6);
    queue_response(RESP_GRANTED);
    queue_ticks(2, PRESS_HIGH);
    queue_ticks(1, PRESS_LOW);
    queue_card(random_uid(), 3'd1);
    queue_response(RESP_GRANTED);
    queue_ticks(1, PRESS_LOW);
    queue_ticks(1, PRESS_HIGH);
    queue_identity();

    phase = 0;
    while (queued < ITEM_GOAL) begin
      phase++;
      wait_idle();
      last = (ITEM_GOAL - queued) <= 200;
      if (phase == 2) style = LIM_ZERO;
      else if (phase == 5) style = LIM_FULL;
      else if (phase % 3 == 0) style = LIM_MIXED;
      else style = LIM_SMALL;
      write_reg(CFG_VALIDATING_TIMEOUT, pick_limit(style));
      write_reg(CFG_UNLOCKED_TIMEOUT, pick_limit(style));
      write_reg(CFG_OPEN_ALARM, pick_limit(style));
      write_reg(CFG_DENIED_HOLD, pick_limit(style));
      addr = ADDR_W'($urandom_range(0, 255));
      if (phase == 2) addr = '0;
      else if ($urandom_range(0, 1) != 0) addr[3:0] = $urandom_range(0, 1) ? DIR_INBOUND : DIR_OUTBOUND;
      write_reg(CFG_NODE_ADDRESS, {12'($urandom), addr});
      settings++;
      if (last) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
        stop = ITEM_GOAL;
      end else begin
        src_idle_pct = 10 * $urandom_range(0, 4);
        sink_idle_pct = 10 * $urandom_range(0, 4);
        stop = queued + ((style == LIM_FULL) ? 60 : 150);
      end
      while (queued < stop) queue_visit();
    end
    wait_idle();

    $display("covered %0d items in %0d results under %0d settings", queued, checked, settings);
    $display("entries confirmed %0d, alarms %0d, refusals %0d, mismatches %0d",
             n_confirm, n_alarm, n_refused, errors);
    if (errors == 0) begin
      $display("door_access_sequencer_core_test: clean");
    end else begin
      $display("door_access_sequencer_core_test: errors");
    end
    $finish;
  end

endmodule
